/* rtl/sre_pkg.sv */
// sprite range evaluator package: word types, command and register codes,
// and the small/large sprite size table
// no dependencies
package sre_pkg;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_EVAL  = 1'b1
    } cmd_t;

    typedef enum logic {
        CFG_SIZE_SELECT  = 1'b0,
        CFG_MAX_PER_LINE = 1'b1
    } cfg_index_t;

    localparam int CFG_DATA_W = 6;

    typedef struct packed {
        logic       command;
        logic [7:0] line;
        logic [6:0] obj_index;
        logic [7:0] x_low;
        logic       x_high;
        logic       size_large;
        logic [7:0] y_raw;
        logic [7:0] tile_low;
        logic [7:0] attrib;
    } in_word_t;

    typedef struct packed {
        logic [6:0] sel_index;
        logic [4:0] slot;
        logic [8:0] tile;
        logic [2:0] palette;
        logic [1:0] priority_res;
        logic       hflip;
        logic [5:0] vflip_xor;
        logic [8:0] pos_x;
        logic [5:0] row_in_sprite;
        logic [6:0] width;
        logic [6:0] height;
    } out_word_t;

    // queued word: line start marker or a decoded, range-selected sprite
    typedef struct packed {
        logic      is_start;
        out_word_t word;
    } q_entry_t;

    function automatic logic [6:0] size_width(input logic [2:0] sel, input logic is_large);
        logic [6:0] w;
        begin
            unique case (sel)
                3'd0: w = is_large ? 7'd16 : 7'd8;
                3'd1: w = is_large ? 7'd32 : 7'd8;
                3'd2: w = is_large ? 7'd64 : 7'd8;
                3'd3: w = is_large ? 7'd32 : 7'd16;
                3'd4: w = is_large ? 7'd64 : 7'd16;
                3'd5: w = is_large ? 7'd64 : 7'd32;
                3'd6: w = is_large ? 7'd32 : 7'd16;
                3'd7: w = is_large ? 7'd32 : 7'd16;
                default: w = 7'd8;
            endcase
            return w;
        end
    endfunction

    function automatic logic [6:0] size_height(input logic [2:0] sel, input logic is_large);
        logic [6:0] h;
        begin
            unique case (sel)
                3'd0: h = is_large ? 7'd16 : 7'd8;
                3'd1: h = is_large ? 7'd32 : 7'd8;
                3'd2: h = is_large ? 7'd64 : 7'd8;
                3'd3: h = is_large ? 7'd32 : 7'd16;
                3'd4: h = is_large ? 7'd64 : 7'd16;
                3'd5: h = is_large ? 7'd64 : 7'd32;
                3'd6: h = is_large ? 7'd64 : 7'd32;
                3'd7: h = is_large ? 7'd32 : 7'd32;
                default: h = 7'd8;
            endcase
            return h;
        end
    endfunction

endpackage

/* rtl/sre_front.sv */
// front end: accepts input words, decodes size, row and visibility,
// and pushes line starts and selected sprites into the queue
// depends on sre_pkg
module sre_front
    import sre_pkg::*;
#(
    parameter int TABLE_ENTRIES = 128
)(
    input  logic       in_valid,
    output logic       in_ready,
    input  in_word_t   in_word,
    input  logic [2:0] size_select,
    input  logic       q_full,
    output logic       q_push,
    output q_entry_t   q_data
);

    localparam int          RECIP_SHIFT = 14;
    localparam logic [14:0] RECIP       =
        15'((2 ** RECIP_SHIFT + TABLE_ENTRIES - 1) / TABLE_ENTRIES);

    logic [6:0]  w;
    logic [6:0]  h;
    logic [7:0]  top;
    logic [7:0]  row;
    logic [8:0]  pos;
    logic [9:0]  neg_dist;
    logic        x_vis;
    logic        hit;
    logic        is_start;
    logic [21:0] idx_prod;
    logic [6:0]  idx_quot;
    logic [13:0] idx_back;
    logic [6:0]  rem;

    always_comb
    begin
        w        = size_width(size_select, in_word.size_large);
        h        = size_height(size_select, in_word.size_large);
        top      = in_word.y_raw + 8'd1;
        row      = in_word.line - top;
        pos      = {in_word.x_high, in_word.x_low};
        neg_dist = 10'd512 - {1'b0, pos};
        if (pos == 9'h100)
            x_vis = 1'b1;
        else if (pos[8])
            x_vis = neg_dist < {3'd0, w};
        else
            x_vis = 1'b1;
        hit      = ({1'b0, row} < {2'd0, h}) && x_vis;
        is_start = (in_word.command == CMD_START);

        // index modulo table size by reciprocal multiply
        idx_prod = 22'(in_word.obj_index) * 22'(RECIP);
        idx_quot = idx_prod[RECIP_SHIFT+6:RECIP_SHIFT];
        idx_back = 14'(idx_quot) * 14'(TABLE_ENTRIES);
        rem      = in_word.obj_index - idx_back[6:0];
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full && (is_start || hit);

    always_comb
    begin
        q_data                    = '0;
        q_data.is_start           = is_start;
        q_data.word.sel_index     = rem;
        q_data.word.slot          = 5'd0;
        q_data.word.tile          = {in_word.attrib[0], in_word.tile_low};
        q_data.word.palette       = in_word.attrib[3:1];
        q_data.word.priority_res  = in_word.attrib[5:4];
        q_data.word.hflip         = in_word.attrib[6];
        q_data.word.vflip_xor     = in_word.attrib[7] ? 6'(w - 7'd1) : 6'd0;
        q_data.word.pos_x         = pos;
        q_data.word.row_in_sprite = row[5:0];
        q_data.word.width         = w;
        q_data.word.height        = h;
    end

endmodule

/* rtl/sre_queue.sv */
// four-entry word queue between front and back ends
// depends on sre_pkg
module sre_queue
    import sre_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_data,
    output logic     full,
    input  logic     pop,
    output logic     empty,
    output q_entry_t pop_data
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    q_entry_t        mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [AW:0]     count_reg;
    logic [AW:0]     count_next;

    assign full     = (count_reg == (AW+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/sre_back.sv */
// back end: per-line selection count and limit, slot assignment,
// and the output register
// depends on sre_pkg
module sre_back
    import sre_pkg::*;
#(
    parameter int MAX_LIST = 32
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [5:0] max_per_line,
    input  logic       q_empty,
    input  q_entry_t   q_data,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output out_word_t  out_word
);

    localparam int CW = $clog2(MAX_LIST + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          full_reg;
    logic          full_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    out_word_t     out_word_reg;
    out_word_t     out_word_next;
    logic [6:0]    limit;
    logic [6:0]    count_inc;
    logic          take;

    always_comb
    begin
        limit = (max_per_line == 6'd0) ? 7'd1 : {1'b0, max_per_line};
        if (limit > 7'(MAX_LIST))
            limit = 7'(MAX_LIST);
        count_inc = 7'(count_reg) + 7'd1;

        q_pop = !q_empty && (q_data.is_start || full_reg || !out_valid_reg || out_ready);
        take  = q_pop && !q_data.is_start && !full_reg;

        count_next     = count_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;

        if (q_pop && q_data.is_start)
        begin
            count_next = '0;
            full_next  = 1'b0;
        end
        else if (take)
        begin
            out_valid_next     = 1'b1;
            out_word_next      = q_data.word;
            out_word_next.slot = 5'(count_reg);
            count_next         = CW'(count_inc);
            full_next          = (count_inc >= limit);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/sprite_range_evaluator_top.sv */
// Sprite range evaluator. One word is accepted per clock while the queue is
// not full: a line start clears the per-line selection count, an evaluate
// word decodes one raw sprite attribute entry and passes it on if the
// scanline falls within its rows and it is horizontally visible. Words that
// miss leave the front end in the cycle they arrive; line starts and hits
// go through a four-entry queue to the back end, which assigns list slots,
// drops sprites once the line limit is reached and holds each result in an
// output register. The sustained rate is one word per cycle when the output
// side keeps up; the queue and output register absorb short output stalls.
// A hit passes the queue, then the output register. Configuration writes
// take effect on the next cycle and are meant for idle periods.
// depends on sre_pkg, sre_front, sre_queue, sre_back
module sprite_range_evaluator_top
    import sre_pkg::*;
#(
    parameter int MAX_LIST      = 32,
    parameter int TABLE_ENTRIES = 128
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_word_t              in_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_word_t             out_word,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [2:0] size_select_reg;
    logic [5:0] max_per_line_reg;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    q_entry_t   q_in;
    q_entry_t   q_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_select_reg  <= 3'd0;
            max_per_line_reg <= 6'd32;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SIZE_SELECT:  size_select_reg  <= cfg_data[2:0];
                CFG_MAX_PER_LINE: max_per_line_reg <= cfg_data[5:0];
                default:          size_select_reg  <= size_select_reg;
            endcase
        end
    end

    sre_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_word     (in_word),
        .size_select (size_select_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    sre_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_out)
    );

    sre_back #(
        .MAX_LIST (MAX_LIST)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .max_per_line (max_per_line_reg),
        .q_empty      (q_empty),
        .q_data       (q_out),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_word     (out_word)
    );

endmodule
